// File: rtl/core/tvsb_pkg.sv
// Shared types and constants of the top-view segment buffer.
// No dependencies; imported by every module of the block.
package tvsb_pkg;

	// buffer geometry
	localparam int CELLS       = 32;
	localparam int TAG_BITS    = 8;
	localparam int HEIGHT_BITS = 8;

	// fixed port widths
	localparam int POS_W    = 6;
	localparam int TAG_W    = 8;
	localparam int HEIGHT_W = 8;

	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int END_W = $clog2(CELLS + 1);
	localparam int CMP_W = (END_W > POS_W) ? END_W : POS_W;

	// request codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	typedef struct packed {
		logic                   occ;
		logic [TAG_BITS-1:0]    tag;
		logic [HEIGHT_BITS-1:0] height;
	} cell_t;

	// broadcast to every cell
	typedef struct packed {
		logic                   shift;
		logic                   ins_en;
		logic [POS_W-1:0]       lo;
		logic [POS_W-1:0]       hi;
		logic [TAG_BITS-1:0]    tag;
		logic [HEIGHT_BITS-1:0] height;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_STEP,
		OP_CLOSE,
		OP_LAST
	} run_op_t;

	typedef struct packed {
		run_op_t          op;
		logic [IDX_W-1:0] idx;
	} run_ctl_t;

	typedef struct packed {
		logic stall;
	} run_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE,
		ST_LAST
	} state_t;

endpackage

// File: rtl/core/tvsb_cell.sv
// One buffer cell: holds a segment, takes its neighbour's on a shift,
// resolves an insert against its own position. Uses tvsb_pkg.
module tvsb_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [tvsb_pkg::IDX_W-1:0] idx,
	input  tvsb_pkg::chain_ctl_t ctl,
	input  tvsb_pkg::cell_t      nxt,
	output tvsb_pkg::cell_t      cur
);
	import tvsb_pkg::*;

	cell_t cell_q;
	logic  hit;
	logic  wins;

	// covered when lo <= idx < hi
	assign hit  = (CMP_W'(ctl.lo) <= CMP_W'(idx)) && (CMP_W'(idx) < CMP_W'(ctl.hi));
	// strictly higher only; an equal height keeps the earlier segment
	assign wins = !cell_q.occ || (cell_q.height < ctl.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctl.shift) begin
			cell_q <= nxt;
		end else if (ctl.ins_en && hit && wins) begin
			cell_q.occ    <= 1'b1;
			cell_q.tag    <= ctl.tag;
			cell_q.height <= ctl.height;
		end
	end

	assign cur = cell_q;

endmodule

// File: rtl/core/tvsb_chain.sv
// Ring of CELLS buffer cells; a shift rotates the ring by one towards cell 0.
// Uses tvsb_pkg and tvsb_cell.
module tvsb_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tvsb_pkg::chain_ctl_t ctl,
	output tvsb_pkg::cell_t      head
);
	import tvsb_pkg::*;

	cell_t cur [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		tvsb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.ctl    (ctl),
			.nxt    (cur[(i + 1) % CELLS]),
			.cur    (cur[i])
		);
	end

	assign head = cur[0];

endmodule

// File: rtl/core/tvsb_run.sv
// Run tracker: merges the cells seen at the ring head into runs, holds the
// newest finished run back so the final one can be marked, and owns the
// output register. Uses tvsb_pkg.
module tvsb_run (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tvsb_pkg::run_ctl_t          ctl,
	input  tvsb_pkg::cell_t             head,
	output tvsb_pkg::run_stat_t         stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        run_valid,
	output logic [tvsb_pkg::POS_W-1:0]  run_start,
	output logic [tvsb_pkg::POS_W-1:0]  run_end,
	output logic [tvsb_pkg::TAG_W-1:0]  run_tag,
	output logic [tvsb_pkg::HEIGHT_W-1:0] run_height,
	output logic                        run_last
);
	import tvsb_pkg::*;

	// open run
	logic                   open_q;
	logic [POS_W-1:0]       start_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic [HEIGHT_BITS-1:0] height_q;
	// finished run held back
	logic                   pend_q;
	logic [POS_W-1:0]       pend_start_q;
	logic [POS_W-1:0]       pend_end_q;
	logic [TAG_BITS-1:0]    pend_tag_q;
	logic [HEIGHT_BITS-1:0] pend_height_q;
	// output register
	logic                   out_valid_q;
	logic                   o_valid_q;
	logic [POS_W-1:0]       o_start_q;
	logic [POS_W-1:0]       o_end_q;
	logic [TAG_W-1:0]       o_tag_q;
	logic [HEIGHT_W-1:0]    o_height_q;
	logic                   o_last_q;

	logic             close;
	logic [POS_W-1:0] close_end;
	logic             push;
	logic             stall;
	logic             go;

	always_comb begin
		close     = 1'b0;
		close_end = POS_W'(ctl.idx);
		case (ctl.op)
			OP_STEP: begin
				close = open_q && (!head.occ || (head.tag != tag_q));
			end
			OP_CLOSE: begin
				close     = open_q;
				close_end = POS_W'(CELLS);
			end
			default: begin
				close = 1'b0;
			end
		endcase
		push  = (close && pend_q) || (ctl.op == OP_LAST);
		stall = push && out_valid_q && !out_ready;
		go    = !stall;
	end

	assign stat.stall = stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				if (push) begin
					out_valid_q <= 1'b1;
				end
				case (ctl.op)
					OP_INIT: begin
						open_q <= 1'b0;
						pend_q <= 1'b0;
					end
					OP_STEP: begin
						if (close) begin
							pend_q <= 1'b1;
						end
						if (head.occ && (!open_q || close)) begin
							open_q <= 1'b1;
						end else if (!head.occ) begin
							open_q <= 1'b0;
						end
					end
					OP_CLOSE: begin
						if (close) begin
							pend_q <= 1'b1;
						end
						open_q <= 1'b0;
					end
					OP_LAST: begin
						pend_q <= 1'b0;
					end
					default: begin
						open_q <= open_q;
					end
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (go) begin
			if (ctl.op == OP_STEP && head.occ && (!open_q || close)) begin
				start_q  <= POS_W'(ctl.idx);
				tag_q    <= head.tag;
				height_q <= head.height;
			end
			if (push) begin
				o_valid_q  <= pend_q;
				o_start_q  <= pend_q ? pend_start_q : '0;
				o_end_q    <= pend_q ? pend_end_q : '0;
				o_tag_q    <= pend_q ? TAG_W'(pend_tag_q) : '0;
				o_height_q <= pend_q ? HEIGHT_W'(pend_height_q) : '0;
				o_last_q   <= (ctl.op == OP_LAST);
			end
			if (close) begin
				pend_start_q  <= start_q;
				pend_end_q    <= close_end;
				pend_tag_q    <= tag_q;
				pend_height_q <= height_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign run_valid  = o_valid_q;
	assign run_start  = o_start_q;
	assign run_end    = o_end_q;
	assign run_tag    = o_tag_q;
	assign run_height = o_height_q;
	assign run_last   = o_last_q;

endmodule

// File: rtl/core/top_view_segment_buffer_unit.sv
// Top level of the top-view segment buffer: sequencer, ring of cells, run tracker.
// Uses tvsb_pkg, tvsb_chain and tvsb_run.
//
// A one-dimensional depth buffer of CELLS unit cells, seen from above. An insert
// request (cmd 0) lays a segment over cells seg_left .. seg_right-1; each covered
// cell keeps the strictly higher segment, so on equal height the earlier one
// stays. Reversed or out-of-range endpoints are dropped. Every cell resolves an
// insert in parallel against its own position. A report request (cmd 1) spends
// its accepting cycle clearing the run tracker, rotates the ring of cells once
// past the head cell, one cell a cycle while the output does not stall, then
// closes the last run in ST_CLOSE and emits the final result in ST_LAST. It
// returns one result per run of adjacent cells holding the same tag, the last
// marked run_last; an empty buffer gives a single result with run_valid 0 and
// run_last 1. The ring's rotation sets the report time. A new request is taken
// only when the block is idle; the result register lets the consumer hold the
// final result while the next request is already accepted. Reset clears every
// cell.
module top_view_segment_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [tvsb_pkg::POS_W-1:0]    seg_left,
	input  logic [tvsb_pkg::POS_W-1:0]    seg_right,
	input  logic [tvsb_pkg::TAG_W-1:0]    seg_tag,
	input  logic [tvsb_pkg::HEIGHT_W-1:0] seg_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          run_valid,
	output logic [tvsb_pkg::POS_W-1:0]    run_start,
	output logic [tvsb_pkg::POS_W-1:0]    run_end,
	output logic [tvsb_pkg::TAG_W-1:0]    run_tag,
	output logic [tvsb_pkg::HEIGHT_W-1:0] run_height,
	output logic                          run_last
);
	import tvsb_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	chain_ctl_t chain_ctl;
	run_ctl_t   run_ctl;
	run_stat_t  run_stat;
	cell_t      head;

	logic accept;
	logic ins_ok;

	assign accept = in_valid && in_ready;

	// insert is legal when left <= right <= CELLS
	assign ins_ok = (seg_left <= seg_right) && (CMP_W'(seg_right) <= CMP_W'(CELLS));

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		idx_d            = idx_q;
		in_ready         = 1'b0;
		run_ctl.op       = OP_NONE;
		run_ctl.idx      = idx_q;
		chain_ctl.shift  = 1'b0;
		chain_ctl.ins_en = 1'b0;
		chain_ctl.lo     = seg_left;
		chain_ctl.hi     = seg_right;
		chain_ctl.tag    = TAG_BITS'(seg_tag);
		chain_ctl.height = HEIGHT_BITS'(seg_height);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (cmd == CMD_REPORT) begin
						run_ctl.op = OP_INIT;
						idx_d      = '0;
						state_d    = ST_SCAN;
					end else begin
						chain_ctl.ins_en = ins_ok;
					end
				end
			end
			ST_SCAN: begin
				// head cell holds physical cell idx_q
				run_ctl.op = OP_STEP;
				if (!run_stat.stall) begin
					chain_ctl.shift = 1'b1;
					idx_d           = idx_q + 1'b1;
					if (idx_q == IDX_W'(CELLS - 1)) begin
						idx_d   = '0;
						state_d = ST_CLOSE;
					end
				end
			end
			ST_CLOSE: begin
				run_ctl.op = OP_CLOSE;
				if (!run_stat.stall) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				run_ctl.op = OP_LAST;
				if (!run_stat.stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- datapath ----
	tvsb_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.head   (head)
	);

	tvsb_run u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (run_ctl),
		.head       (head),
		.stat       (run_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_valid  (run_valid),
		.run_start  (run_start),
		.run_end    (run_end),
		.run_tag    (run_tag),
		.run_height (run_height),
		.run_last   (run_last)
	);

`ifndef SYNTHESIS
	// an empty result only ever closes a report
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_valid) |-> run_last)
		else $error("empty result without last mark");

	// a reported run covers at least one cell
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_valid) |-> (run_start < run_end))
		else $error("reported run is empty or reversed");

	// the final step of a report leaves a last-marked result and returns to idle
	a_last_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST && !run_stat.stall)
			|=> (state_q == ST_IDLE && out_valid && run_last))
		else $error("report ended without a last result");

	// each unstalled scan step advances the ring position by one
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !run_stat.stall)
			|=> (idx_q == $past(idx_q) + 1'b1 || state_q == ST_CLOSE))
		else $error("scan position skipped");
`endif

endmodule
